// ----- hdl/sbms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared buffer multi-stack package
// Sizes, payload types, status codes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbms_pkg;

   // Geometry of the shared buffer.
   localparam int NUM_STACKS  = 4;
   localparam int STACK_DEPTH = 16;
   localparam int BUF_SLOTS   = NUM_STACKS * STACK_DEPTH;
   localparam int DATA_W      = 32;
   localparam int STK_W       = $clog2(NUM_STACKS);
   localparam int SLOT_W      = $clog2(BUF_SLOTS);
   localparam int CNT_W       = $clog2(BUF_SLOTS + 1);
   localparam int SUM_W       = SLOT_W + 1;

   // Operation codes of the action field.
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic                     action;
      logic [1:0]               stack_sel;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pop_value;
      status_type               status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SEARCH,
      ST_MOVE,
      ST_MOVE_LOAD,
      ST_PUSH_WR,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       use_sel;
      logic       set_code;
      status_type code;
      logic       push_wr;
      logic       room_inc;
      logic       pop_rd;
      logic       search_start;
      logic       search_step;
      logic       search_end;
      logic       load_k;
      logic       move_step;
      logic       stack_done;
      logic       rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_push;
      logic sel_ok;
      logic buf_full;
      logic idx_empty;
      logic idx_full;
      logic cur_is_sel;
      logic cur_is_last;
      logic move_idle;
      logic out_free;
   } sts_type;

   // Next stack around the ring.
   function automatic logic [STK_W-1:0] stack_next(input logic [STK_W-1:0] s);
      if (s == STK_W'(NUM_STACKS - 1)) begin
         return '0;
      end
      return s + STK_W'(1);
   endfunction

   // Previous stack around the ring.
   function automatic logic [STK_W-1:0] stack_prev(input logic [STK_W-1:0] s);
      if (s == '0) begin
         return STK_W'(NUM_STACKS - 1);
      end
      return s - STK_W'(1);
   endfunction

   // Slot address base + off, wrapped around the buffer (off is at most BUF_SLOTS).
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(BUF_SLOTS)) begin
         sum = sum - SUM_W'(BUF_SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

// ----- hdl/sbms_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared buffer multi-stack controller
// Sequences one transaction at a time: decide, search for a stack with room,
// shift the full neighbours up slot by slot, write the push, answer.
// ----------------------------------------------------------------------------
module sbms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sbms_pkg::sts_type sts,
   output sbms_pkg::cmd_type cmd
);
   import sbms_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.code  = STATUS_OK;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.use_sel  = 1'b1;
            cmd.set_code = 1'b1;
            if (sts.is_push) begin
               if (!sts.sel_ok || sts.buf_full) begin
                  cmd.code = STATUS_OVERFLOW;
                  state_in = ST_FINISH;
               end else if (!sts.idx_full) begin
                  cmd.push_wr = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  cmd.search_start = 1'b1;
                  state_in         = ST_SEARCH;
               end
            end else begin
               if (!sts.sel_ok || sts.idx_empty) begin
                  cmd.code = STATUS_UNDERFLOW;
               end else begin
                  cmd.pop_rd = 1'b1;
               end
               state_in = ST_FINISH;
            end
         end
         ST_SEARCH: begin
            // Walk forward past full neighbours to the first one with a free slot.
            if (sts.idx_full && !sts.cur_is_sel) begin
               cmd.search_step = 1'b1;
            end else begin
               cmd.search_end = 1'b1;
               state_in       = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (!sts.move_idle) begin
               cmd.move_step = 1'b1;
            end else begin
               cmd.stack_done = 1'b1;
               state_in       = sts.cur_is_last ? ST_PUSH_WR : ST_MOVE_LOAD;
            end
         end
         ST_MOVE_LOAD: begin
            cmd.load_k = 1'b1;
            state_in   = ST_MOVE;
         end
         ST_PUSH_WR: begin
            cmd.use_sel  = 1'b1;
            cmd.push_wr  = 1'b1;
            cmd.room_inc = 1'b1;
            cmd.set_code = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/sbms_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared buffer multi-stack datapath
// Per-stack start, fill and room registers, the shared slot memory with its
// registered read port, the shift pipeline and the output register.
// ----------------------------------------------------------------------------
module sbms_datapath (
   input  logic              clock,
   input  logic              reset,
   input  sbms_pkg::cmd_type cmd,
   output sbms_pkg::sts_type sts,
   input  sbms_pkg::req_type req_data,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output sbms_pkg::rsp_type rsp_data
);
   import sbms_pkg::*;

   req_type                  op_ff, op_in;
   logic [STK_W-1:0]         cur_ff, cur_in;
   logic [STK_W-1:0]         sel_idx, idx;
   logic [SLOT_W-1:0]        start_ff [NUM_STACKS];
   logic [SLOT_W-1:0]        start_in [NUM_STACKS];
   logic [CNT_W-1:0]         fill_ff [NUM_STACKS];
   logic [CNT_W-1:0]         fill_in [NUM_STACKS];
   logic [CNT_W-1:0]         room_ff [NUM_STACKS];
   logic [CNT_W-1:0]         room_in [NUM_STACKS];
   logic [CNT_W-1:0]         total_ff, total_in;
   logic [CNT_W-1:0]         k_ff, k_in;
   logic                     pend_ff, pend_in;
   logic [SLOT_W-1:0]        dst_ff, dst_in;
   status_type               code_ff, code_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic signed [DATA_W-1:0] mem [BUF_SLOTS];
   logic signed [DATA_W-1:0] rd_ff;
   logic                     mem_we, mem_re;
   logic [SLOT_W-1:0]        mem_wa, mem_ra;
   logic signed [DATA_W-1:0] mem_wd;

   logic                     sel_ok;
   logic [SLOT_W-1:0]        idx_start;
   logic [CNT_W-1:0]         idx_fill, idx_room;

   // One stack is addressed per cycle: the selected one or the walking pointer.
   assign sel_ok    = int'(op_ff.stack_sel) < NUM_STACKS;
   assign sel_idx   = STK_W'(op_ff.stack_sel);
   assign idx       = cmd.use_sel ? sel_idx : cur_ff;
   assign idx_start = start_ff[idx];
   assign idx_fill  = fill_ff[idx];
   assign idx_room  = room_ff[idx];

   // Status toward the controller.
   always_comb begin
      sts.is_push     = op_ff.action == ACT_PUSH;
      sts.sel_ok      = sel_ok;
      sts.buf_full    = total_ff >= CNT_W'(BUF_SLOTS);
      sts.idx_empty   = idx_fill == '0;
      sts.idx_full    = idx_fill >= idx_room;
      sts.cur_is_sel  = cur_ff == sel_idx;
      sts.cur_is_last = cur_ff == stack_next(sel_idx);
      sts.move_idle   = (k_ff == '0) && !pend_ff;
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // Next values of the bookkeeping registers and the memory port controls.
   always_comb begin
      op_in    = op_ff;
      cur_in   = cur_ff;
      start_in = start_ff;
      fill_in  = fill_ff;
      room_in  = room_ff;
      total_in = total_ff;
      k_in     = k_ff;
      pend_in  = pend_ff;
      dst_in   = dst_ff;
      code_in  = code_ff;
      mem_we   = 1'b0;
      mem_wa   = slot_add(idx_start, idx_fill);
      mem_wd   = op_ff.push_value;
      mem_re   = 1'b0;
      mem_ra   = slot_add(idx_start, idx_fill - CNT_W'(1));

      if (cmd.load_req) begin
         op_in = req_data;
      end
      if (cmd.set_code) begin
         code_in = cmd.code;
      end

      // Ring pointer for the search and the backward shift walk.
      if (cmd.search_start) begin
         cur_in = stack_next(sel_idx);
      end else if (cmd.search_step) begin
         cur_in = stack_next(cur_ff);
      end else if (cmd.stack_done) begin
         cur_in = stack_prev(cur_ff);
      end

      // Push writes the new top; pop reads the old top.
      if (cmd.push_wr) begin
         mem_we        = 1'b1;
         fill_in[idx]  = idx_fill + CNT_W'(1);
         total_in      = total_ff + CNT_W'(1);
      end
      if (cmd.room_inc) begin
         room_in[idx] = idx_room + CNT_W'(1);
      end
      if (cmd.pop_rd) begin
         mem_re       = 1'b1;
         fill_in[idx] = idx_fill - CNT_W'(1);
         total_in     = total_ff - CNT_W'(1);
      end

      // The stack that ends the chain gives up one slot.
      if (cmd.search_end && (idx_room != '0)) begin
         room_in[idx] = idx_room - CNT_W'(1);
      end
      if (cmd.search_end || cmd.load_k) begin
         k_in    = idx_fill;
         pend_in = 1'b0;
      end

      // Shift pipeline: read slot k-1 while writing the slot read last cycle.
      if (cmd.move_step) begin
         if (pend_ff) begin
            mem_we = 1'b1;
            mem_wa = dst_ff;
            mem_wd = rd_ff;
         end
         if (k_ff != '0) begin
            mem_re = 1'b1;
            mem_ra = slot_add(idx_start, k_ff - CNT_W'(1));
            dst_in = slot_add(idx_start, k_ff);
            k_in   = k_ff - CNT_W'(1);
         end
         pend_in = k_ff != '0;
      end
      if (cmd.stack_done) begin
         start_in[idx] = slot_add(idx_start, CNT_W'(1));
      end
   end

   // Output register: holds the answer until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.status    = code_ff;
         rsp_in.pop_value = ((code_ff == STATUS_OK) && (op_ff.action == ACT_POP)) ?
                            rd_ff : '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            start_ff[i] <= SLOT_W'(i * STACK_DEPTH);
            fill_ff[i]  <= '0;
            room_ff[i]  <= CNT_W'(STACK_DEPTH);
         end
         total_ff     <= '0;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         fill_ff      <= fill_in;
         room_ff      <= room_in;
         total_ff     <= total_in;
         k_ff         <= k_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cur_ff  <= cur_in;
      dst_ff  <= dst_in;
      code_ff <= code_in;
      rsp_ff  <= rsp_in;
   end

   // Shared slot memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/shared_buffer_multi_stack.sv -----
`timescale 1ns / 1ps
// A pop, a rejected push or a push into free room is decided and then answered, and the
// next transaction can be taken once the answer has been loaded into the output register.
// A push onto a full stack adds a search step per stack searched, a shift step per slot
// moved, closing steps per shifted stack, a reload per further stack and the final write.
// One transaction at a time; a new one is taken while the last answer waits.
// Synchronous reset restores the even split with all stacks empty.
// ----------------------------------------------------------------------------
// Shared buffer multi-stack
// Several stacks in one circular buffer; a full stack borrows slots from its
// neighbours around the ring, shifting their contents up by one.
// ----------------------------------------------------------------------------
module shared_buffer_multi_stack (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sbms_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sbms_pkg::rsp_type rsp_data
);
   import sbms_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   sbms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   sbms_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
